/* rtl/vacuum_leak_test_sequencer_defines.svh */
// Assertion macros shared by the vacuum leak test sequencer modules.
// No dependencies; every user module must have clk and arst_n in scope.
`ifndef VACUUM_LEAK_TEST_SEQUENCER_DEFINES_SVH
`define VACUUM_LEAK_TEST_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VLTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VLTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/vlts_pkg.sv */
// Package of the vacuum leak test sequencer: widths, codes, command structs
// and saturation helpers. No dependencies.
package vlts_pkg;

	// Pressure, internal sum, elapsed counter, configuration data and register index widths.
	localparam int P_W   = 21;
	localparam int SUM_W = 34;
	localparam int EL_W  = 17;
	localparam int CFG_W = 21;
	localparam int IDX_W = 3;

	localparam int P_MAX = 1000000;
	localparam int P_MIN = -1000000;
	localparam logic [EL_W-1:0] ELAPSED_MAX = {EL_W{1'b1}};

	// Filter weight in Q8.
	localparam int ALPHA_Q8 = 26;
	localparam logic signed [9:0] ALPHA_S = 10'(ALPHA_Q8);

	typedef logic [1:0] func_t;
	typedef logic [2:0] mode_t;
	typedef logic [3:0] ev_t;
	typedef logic [IDX_W-1:0] reg_idx_t;

	localparam func_t FUNC_TICK = 2'd0;
	localparam func_t FUNC_ON   = 2'd1;
	localparam func_t FUNC_OFF  = 2'd2;
	localparam func_t FUNC_LEAK = 2'd3;

	localparam mode_t MODE_OFF    = 3'd0;
	localparam mode_t MODE_HOLD   = 3'd1;
	localparam mode_t MODE_PULL   = 3'd2;
	localparam mode_t MODE_SETTLE = 3'd3;
	localparam mode_t MODE_MEAS   = 3'd4;
	localparam mode_t MODE_ERR    = 3'd5;

	localparam ev_t EV_NONE      = 4'd0;
	localparam ev_t EV_HOLD      = 4'd1;
	localparam ev_t EV_START     = 4'd2;
	localparam ev_t EV_BUSY      = 4'd3;
	localparam ev_t EV_OFF       = 4'd4;
	localparam ev_t EV_ALRDY_OFF = 4'd5;
	localparam ev_t EV_SETTLE    = 4'd6;
	localparam ev_t EV_MEASURE   = 4'd7;
	localparam ev_t EV_TIMEOUT   = 4'd8;
	localparam ev_t EV_LEAK_FAIL = 4'd9;
	localparam ev_t EV_PASS      = 4'd10;

	localparam reg_idx_t REG_TARGET   = 3'd0;
	localparam reg_idx_t REG_RAMP_TO  = 3'd1;
	localparam reg_idx_t REG_LEAK_LIM = 3'd2;
	localparam reg_idx_t REG_LEAK_WIN = 3'd3;
	localparam reg_idx_t REG_SETTLE   = 3'd4;
	localparam reg_idx_t REG_GAIN     = 3'd5;
	localparam reg_idx_t REG_ZERO     = 3'd6;
	localparam reg_idx_t REG_OFFSET   = 3'd7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // latch the item and start the sensor multiply
		logic ewma;     // form the weighted filter difference
		logic smooth;   // update the smoothed pressure
		logic step;     // run the mode machine and load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tick;
	} stat_t;

	function automatic logic signed [P_W-1:0] sat_p(input logic signed [SUM_W-1:0] v);
		logic signed [P_W-1:0] r;
		if (v > SUM_W'(P_MAX))
			r = P_W'(P_MAX);
		else if (v < SUM_W'(P_MIN))
			r = P_W'(P_MIN);
		else
			r = P_W'(v);
		return r;
	endfunction

	// A time limit counts as exceeded past the limit or once the counter saturated.
	function automatic logic exceeded(input logic [EL_W-1:0] el, input logic [EL_W-1:0] lim);
		return (el > lim) || (el == ELAPSED_MAX);
	endfunction

endpackage

/* rtl/vlts_if.sv */
// Channel interfaces of the vacuum leak test sequencer: input items, results
// and configuration writes. Depends on vlts_pkg.
interface vlts_in_if;
	logic              valid;
	logic              ready;
	vlts_pkg::func_t   func;
	logic [11:0]       adc_sample;

	modport source (output valid, func, adc_sample, input ready);
	modport sink (input valid, func, adc_sample, output ready);
endinterface

interface vlts_out_if;
	logic                                valid;
	logic                                ready;
	vlts_pkg::mode_t                     mode;
	logic                                pump_on;
	logic                                valve_open;
	logic signed [vlts_pkg::P_W-1:0]     pressure_mpsi;
	vlts_pkg::ev_t                       event_res;
	logic signed [vlts_pkg::P_W-1:0]     loss_mpsi;

	modport source (output valid, mode, pump_on, valve_open, pressure_mpsi, event_res,
		loss_mpsi, input ready);
	modport sink (input valid, mode, pump_on, valve_open, pressure_mpsi, event_res,
		loss_mpsi, output ready);
endinterface

interface vlts_cfg_if;
	logic                          valid;
	logic                          ready;
	vlts_pkg::reg_idx_t            index;
	logic [vlts_pkg::CFG_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/vlts_datapath.sv */
// Datapath of the vacuum leak test sequencer: configuration registers, sensor
// scaling, smoothing filter, mode machine state and result register.
// Depends on vlts_pkg and the assertion macro header.
`include "vacuum_leak_test_sequencer_defines.svh"

module vlts_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vlts_pkg::cmd_t                      cmd,
	output vlts_pkg::stat_t                     stat,
	input  logic                                cfg_we,
	input  vlts_pkg::reg_idx_t                  cfg_index,
	input  logic [vlts_pkg::CFG_W-1:0]          cfg_data,
	input  vlts_pkg::func_t                     func,
	input  logic [11:0]                         adc_sample,
	output vlts_pkg::mode_t                     mode,
	output logic                                pump_on,
	output logic                                valve_open,
	output logic signed [vlts_pkg::P_W-1:0]     pressure_mpsi,
	output vlts_pkg::ev_t                       event_res,
	output logic signed [vlts_pkg::P_W-1:0]     loss_mpsi
);

	// Configuration registers.
	logic signed [14:0] target_q;
	logic [15:0]        ramp_to_q;
	logic [12:0]        leak_lim_q;
	logic [16:0]        leak_win_q;
	logic [16:0]        settle_q;
	logic signed [20:0] gain_q;
	logic signed [17:0] zero_q;
	logic signed [13:0] offset_q;

	// Sequencer state.
	vlts_pkg::mode_t                   mode_q;
	logic                              pump_q;
	logic                              valve_q;
	logic                              first_q;
	logic [vlts_pkg::EL_W-1:0]         elapsed_q;
	logic signed [vlts_pkg::P_W-1:0]   smoothed_q;
	logic signed [vlts_pkg::P_W-1:0]   mstart_q;

	// Working registers of one item.
	vlts_pkg::func_t                   func_q;
	logic signed [vlts_pkg::SUM_W-1:0] prod_q;
	logic signed [31:0]                ewma_q;

	// Result register.
	vlts_pkg::mode_t                   out_mode_q;
	logic                              out_pump_q;
	logic                              out_valve_q;
	logic signed [vlts_pkg::P_W-1:0]   out_press_q;
	vlts_pkg::ev_t                     out_ev_q;
	logic signed [vlts_pkg::P_W-1:0]   out_loss_q;

	logic signed [vlts_pkg::SUM_W-1:0] prod_d;
	logic signed [18:0]                raw;
	logic signed [21:0]                diff;
	logic signed [31:0]                ewma_d;
	logic signed [vlts_pkg::SUM_W-1:0] smooth_sum;
	logic signed [vlts_pkg::SUM_W-1:0] press_sum;
	logic signed [vlts_pkg::P_W-1:0]   press;
	logic signed [21:0]                leak_delta;
	logic signed [21:0]                loss_delta;
	logic [vlts_pkg::EL_W-1:0]         el_inc;
	logic                              busy;

	vlts_pkg::mode_t                   mode_n;
	logic                              pump_n;
	logic                              valve_n;
	logic [vlts_pkg::EL_W-1:0]         el_n;
	logic signed [vlts_pkg::P_W-1:0]   mstart_n;
	vlts_pkg::ev_t                     ev_n;
	logic signed [vlts_pkg::P_W-1:0]   loss_n;

	assign stat.is_tick = (func == vlts_pkg::FUNC_TICK);

	// Sensor scaling: zero + floor(gain * adc / 2^16), always inside the pressure range.
	assign prod_d = gain_q * $signed({1'b0, adc_sample});
	assign raw    = 19'(zero_q) + 19'($signed(prod_q[33:16]));
	assign diff   = 22'(raw) - 22'(smoothed_q);
	assign ewma_d = diff * vlts_pkg::ALPHA_S;
	assign smooth_sum = vlts_pkg::SUM_W'(smoothed_q) + vlts_pkg::SUM_W'(ewma_q >>> 8);

	assign press_sum  = vlts_pkg::SUM_W'(smoothed_q) + vlts_pkg::SUM_W'(offset_q);
	assign press      = vlts_pkg::sat_p(press_sum);
	assign leak_delta = 22'(smoothed_q) - 22'(mstart_q);
	assign busy       = !(mode_q == vlts_pkg::MODE_OFF || mode_q == vlts_pkg::MODE_HOLD);

	always_comb begin
		if ((mode_q == vlts_pkg::MODE_PULL || mode_q == vlts_pkg::MODE_SETTLE ||
				mode_q == vlts_pkg::MODE_MEAS) && elapsed_q != vlts_pkg::ELAPSED_MAX)
			el_inc = elapsed_q + 1'b1;
		else
			el_inc = elapsed_q;
	end

	// Mode machine for one item.
	always_comb begin
		mode_n   = mode_q;
		pump_n   = pump_q;
		valve_n  = valve_q;
		el_n     = elapsed_q;
		mstart_n = mstart_q;
		ev_n     = vlts_pkg::EV_NONE;
		unique case (func_q)
			vlts_pkg::FUNC_TICK: begin
				el_n = el_inc;
				priority case (mode_q)
					vlts_pkg::MODE_PULL: begin
						if (press <= 21'(target_q)) begin
							pump_n  = 1'b0;
							valve_n = 1'b0;
							mode_n  = vlts_pkg::MODE_SETTLE;
							el_n    = '0;
							ev_n    = vlts_pkg::EV_SETTLE;
						end else if (vlts_pkg::exceeded(el_inc, 17'(ramp_to_q))) begin
							mode_n = vlts_pkg::MODE_ERR;
							pump_n = 1'b0;
							ev_n   = vlts_pkg::EV_TIMEOUT;
						end
					end
					vlts_pkg::MODE_SETTLE: begin
						if (vlts_pkg::exceeded(el_inc, settle_q)) begin
							mstart_n = smoothed_q;
							mode_n   = vlts_pkg::MODE_MEAS;
							el_n     = '0;
							ev_n     = vlts_pkg::EV_MEASURE;
						end
					end
					vlts_pkg::MODE_MEAS: begin
						if (leak_delta > $signed({9'b0, leak_lim_q})) begin
							mode_n = vlts_pkg::MODE_ERR;
							ev_n   = vlts_pkg::EV_LEAK_FAIL;
						end else if (vlts_pkg::exceeded(el_inc, leak_win_q)) begin
							mode_n  = vlts_pkg::MODE_OFF;
							pump_n  = 1'b0;
							valve_n = 1'b0;
							ev_n    = vlts_pkg::EV_PASS;
						end
					end
					default: ;
				endcase
			end
			vlts_pkg::FUNC_OFF: begin
				if (mode_q == vlts_pkg::MODE_OFF) begin
					ev_n = vlts_pkg::EV_ALRDY_OFF;
				end else begin
					mode_n  = vlts_pkg::MODE_OFF;
					pump_n  = 1'b0;
					valve_n = 1'b0;
					ev_n    = vlts_pkg::EV_OFF;
				end
			end
			vlts_pkg::FUNC_ON: begin
				if (busy) begin
					ev_n = vlts_pkg::EV_BUSY;
				end else begin
					mode_n  = vlts_pkg::MODE_HOLD;
					pump_n  = 1'b1;
					valve_n = 1'b1;
					ev_n    = vlts_pkg::EV_HOLD;
				end
			end
			vlts_pkg::FUNC_LEAK: begin
				if (busy) begin
					ev_n = vlts_pkg::EV_BUSY;
				end else begin
					mode_n  = vlts_pkg::MODE_PULL;
					el_n    = '0;
					pump_n  = 1'b1;
					valve_n = 1'b1;
					ev_n    = vlts_pkg::EV_START;
				end
			end
		endcase
	end

	// The loss is reported only while measuring or on the verdict of a window.
	assign loss_delta = 22'(smoothed_q) - 22'(mstart_n);
	assign loss_n = (mode_n == vlts_pkg::MODE_MEAS || ev_n == vlts_pkg::EV_LEAK_FAIL ||
		ev_n == vlts_pkg::EV_PASS) ? vlts_pkg::sat_p(vlts_pkg::SUM_W'(loss_delta)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= -15'sd10000;
			ramp_to_q  <= 16'd30000;
			leak_lim_q <= 13'd100;
			leak_win_q <= 17'd10000;
			settle_q   <= 17'd2000;
			gain_q     <= '0;
			zero_q     <= '0;
			offset_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vlts_pkg::REG_TARGET:   target_q   <= cfg_data[14:0];
				vlts_pkg::REG_RAMP_TO:  ramp_to_q  <= cfg_data[15:0];
				vlts_pkg::REG_LEAK_LIM: leak_lim_q <= cfg_data[12:0];
				vlts_pkg::REG_LEAK_WIN: leak_win_q <= cfg_data[16:0];
				vlts_pkg::REG_SETTLE:   settle_q   <= cfg_data[16:0];
				vlts_pkg::REG_GAIN:     gain_q     <= cfg_data[20:0];
				vlts_pkg::REG_ZERO:     zero_q     <= cfg_data[17:0];
				vlts_pkg::REG_OFFSET:   offset_q   <= cfg_data[13:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= vlts_pkg::MODE_OFF;
			pump_q     <= 1'b0;
			valve_q    <= 1'b0;
			first_q    <= 1'b1;
			elapsed_q  <= '0;
			smoothed_q <= '0;
			mstart_q   <= '0;
		end else begin
			if (cmd.smooth) begin
				first_q <= 1'b0;
				if (first_q)
					smoothed_q <= 21'(raw);
				else
					smoothed_q <= vlts_pkg::sat_p(smooth_sum);
			end
			if (cmd.step) begin
				mode_q    <= mode_n;
				pump_q    <= pump_n;
				valve_q   <= valve_n;
				elapsed_q <= el_n;
				mstart_q  <= mstart_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= func;
			prod_q <= prod_d;
		end
		if (cmd.ewma)
			ewma_q <= ewma_d;
		if (cmd.step) begin
			out_mode_q  <= mode_n;
			out_pump_q  <= pump_n;
			out_valve_q <= valve_n;
			out_press_q <= press;
			out_ev_q    <= ev_n;
			out_loss_q  <= loss_n;
		end
	end

	assign mode          = out_mode_q;
	assign pump_on       = out_pump_q;
	assign valve_open    = out_valve_q;
	assign pressure_mpsi = out_press_q;
	assign event_res     = out_ev_q;
	assign loss_mpsi     = out_loss_q;

	`VLTS_ASSERT_NOW(a_pump_needs_valve, pump_q, valve_q, "pump running with valve closed")
	`VLTS_ASSERT_NOW(a_off_relays, mode_q == vlts_pkg::MODE_OFF, !pump_q && !valve_q, "relay driven in off mode")
	`VLTS_ASSERT_NOW(a_test_relays, mode_q == vlts_pkg::MODE_SETTLE || mode_q == vlts_pkg::MODE_MEAS, !pump_q && !valve_q, "relay driven during settle or measure")

endmodule

/* rtl/vlts_ctrl.sv */
// Controller of the vacuum leak test sequencer: sequences one item through
// the datapath and owns the handshakes of both item channels. Depends on
// vlts_pkg and the assertion macro header.
`include "vacuum_leak_test_sequencer_defines.svh"

module vlts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  vlts_pkg::stat_t  stat,
	output vlts_pkg::cmd_t   cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EWMA   = 2'd1;
	localparam logic [1:0] S_SMOOTH = 2'd2;
	localparam logic [1:0] S_STEP   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// The result register may be loaded when empty or emptied in the same cycle.
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid)
					state_d = stat.is_tick ? S_EWMA : S_STEP;
			end
			S_EWMA: begin
				cmd.ewma = 1'b1;
				state_d  = S_SMOOTH;
			end
			S_SMOOTH: begin
				cmd.smooth = 1'b1;
				state_d    = S_STEP;
			end
			S_STEP: begin
				cmd.step = out_free;
				if (out_free)
					state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`VLTS_ASSERT_NOW(a_no_overwrite, cmd.step, !out_valid_q || out_ready, "result register overwritten")
	`VLTS_ASSERT_NOW(a_rise_from_step, $rose(out_valid_q), $past(state_q) == S_STEP, "result appeared outside step")
	`VLTS_ASSERT_NEXT(a_cmd_to_step, cmd.accept && !stat.is_tick, state_q == S_STEP, "command item did not go to step")

endmodule

/* rtl/vacuum_leak_test_sequencer.sv */
// Top level of the vacuum leak test sequencer: joins controller and datapath
// to the item, result and configuration channels. Depends on vlts_pkg,
// vlts_if, vlts_ctrl and vlts_datapath.
//
// Usage. Items enter on req (func, adc_sample) with a valid/ready transaction;
// each item gives exactly one result on rsp (mode, relays, pressure, event,
// loss). Tick items pass a sensor multiply, the filter difference, the filter
// update and the mode machine step, in that order; vacuum on, off and leak
// test items go from accept straight to the step. The single shared
// sequencing loop of the controller takes no new item until the one in
// flight has loaded its result. Results sit in an output register, so the
// next item is accepted while the previous result is still waiting; if the
// receiver stalls, the following item waits in its final step until the
// result register is taken. Configuration writes on cfg are always ready
// and are meant for times when no item is in flight. Reset (arst_n low)
// returns the mode to off with both relays released, clears the filter so
// that the next tick is taken as is, and restores the register reset values.
module vacuum_leak_test_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	vlts_cfg_if.sink    cfg,
	vlts_in_if.sink     req,
	vlts_out_if.source  rsp
);

	vlts_pkg::cmd_t  cmd;
	vlts_pkg::stat_t stat;

	// Register writes never stall.
	assign cfg.ready = 1'b1;

	// Sequencing of one item and the handshakes of both item channels.
	vlts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Arithmetic, mode state and the result register.
	vlts_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.func          (req.func),
		.adc_sample    (req.adc_sample),
		.mode          (rsp.mode),
		.pump_on       (rsp.pump_on),
		.valve_open    (rsp.valve_open),
		.pressure_mpsi (rsp.pressure_mpsi),
		.event_res     (rsp.event_res),
		.loss_mpsi     (rsp.loss_mpsi)
	);

endmodule

/* sim/vlts_checker.sv */
// Scoreboard of the vacuum leak test sequencer: predicts one status per accepted item
// from its own copy of the registers and state, and compares the block's results with it.
// Depends on vlts_pkg and the channel interfaces of vlts_if.
module vlts_checker
	import vlts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	vlts_cfg_if  cfg,
	vlts_in_if   req,
	vlts_out_if  rsp,
	output int   fail_count,
	output int   pending
);

	localparam longint PRESS_HI = 1000000;
	localparam longint PRESS_LO = -1000000;
	localparam int     EL_TOP   = 131071;

	typedef struct packed {
		mode_t                 mode;
		logic                  pump;
		logic                  valve;
		logic signed [P_W-1:0] pressure;
		ev_t                   ev;
		logic signed [P_W-1:0] loss;
	} status_t;

	status_t want_q[$];
	int      fails;

	// Register copies, already sign extended or masked to their widths.
	longint target_p, ramp_lim, leak_lim, window_lim, settle_lim;
	longint gain_q16, zero_p, offset_p;

	// Sequencer state.
	mode_t  mode_s;
	longint smooth_p;
	logic   fresh;
	int     elapsed;
	longint meas_base;
	logic   pump_s, valve_s;

	function automatic longint clip(input longint v);
		if (v > PRESS_HI)
			return PRESS_HI;
		if (v < PRESS_LO)
			return PRESS_LO;
		return v;
	endfunction

	function automatic logic past_limit(input longint lim);
		return (elapsed > lim) || (elapsed >= EL_TOP);
	endfunction

	// Applies one item to the state copy and returns the status it leaves behind.
	function automatic status_t advance(input func_t f, input logic [11:0] adc);
		status_t r;
		ev_t     ev;
		longint  raw, press, loss;
		ev = EV_NONE;
		if (f == FUNC_TICK) begin
			raw = clip(zero_p + ((gain_q16 * longint'(adc)) >>> 16));
			if (fresh) begin
				smooth_p = raw;
				fresh = 1'b0;
			end else begin
				smooth_p = clip(smooth_p + ((longint'(ALPHA_Q8) * (raw - smooth_p)) >>> 8));
			end
			press = clip(smooth_p + offset_p);
			if ((mode_s == MODE_PULL || mode_s == MODE_SETTLE || mode_s == MODE_MEAS) &&
				elapsed < EL_TOP)
				elapsed++;
			case (mode_s)
				MODE_PULL: begin
					if (press <= target_p) begin
						pump_s = 1'b0;
						valve_s = 1'b0;
						mode_s = MODE_SETTLE;
						elapsed = 0;
						ev = EV_SETTLE;
					end else if (past_limit(ramp_lim)) begin
						// The valve stays open on a pulldown timeout.
						mode_s = MODE_ERR;
						pump_s = 1'b0;
						ev = EV_TIMEOUT;
					end
				end
				MODE_SETTLE: begin
					if (past_limit(settle_lim)) begin
						meas_base = smooth_p;
						mode_s = MODE_MEAS;
						elapsed = 0;
						ev = EV_MEASURE;
					end
				end
				MODE_MEAS: begin
					if (smooth_p - meas_base > leak_lim) begin
						mode_s = MODE_ERR;
						ev = EV_LEAK_FAIL;
					end else if (past_limit(window_lim)) begin
						mode_s = MODE_OFF;
						pump_s = 1'b0;
						valve_s = 1'b0;
						ev = EV_PASS;
					end
				end
				default: ;
			endcase
		end else if (f == FUNC_OFF) begin
			if (mode_s == MODE_OFF) begin
				ev = EV_ALRDY_OFF;
			end else begin
				mode_s = MODE_OFF;
				pump_s = 1'b0;
				valve_s = 1'b0;
				ev = EV_OFF;
			end
		end else if (mode_s != MODE_OFF && mode_s != MODE_HOLD) begin
			ev = EV_BUSY;
		end else if (f == FUNC_ON) begin
			mode_s = MODE_HOLD;
			pump_s = 1'b1;
			valve_s = 1'b1;
			ev = EV_HOLD;
		end else begin
			mode_s = MODE_PULL;
			elapsed = 0;
			pump_s = 1'b1;
			valve_s = 1'b1;
			ev = EV_START;
		end

		press = clip(smooth_p + offset_p);
		if (mode_s == MODE_MEAS || ev == EV_LEAK_FAIL || ev == EV_PASS)
			loss = clip(smooth_p - meas_base);
		else
			loss = 0;

		r.mode = mode_s;
		r.pump = pump_s;
		r.valve = valve_s;
		r.pressure = P_W'(press);
		r.ev = ev;
		r.loss = P_W'(loss);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_t seen, want;
		if (!arst_n) begin
			target_p = -10000;
			ramp_lim = 30000;
			leak_lim = 100;
			window_lim = 10000;
			settle_lim = 2000;
			gain_q16 = 0;
			zero_p = 0;
			offset_p = 0;
			mode_s = MODE_OFF;
			smooth_p = 0;
			fresh = 1'b1;
			elapsed = 0;
			meas_base = 0;
			pump_s = 1'b0;
			valve_s = 1'b0;
			want_q.delete();
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen.mode = rsp.mode;
				seen.pump = rsp.pump_on;
				seen.valve = rsp.valve_open;
				seen.pressure = rsp.pressure_mpsi;
				seen.ev = rsp.event_res;
				seen.loss = rsp.loss_mpsi;
				if (want_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result: mode %0d event %0d pressure %0d",
							seen.mode, seen.ev, seen.pressure);
				end else begin
					want = want_q.pop_front();
					if (seen.mode !== want.mode || seen.pump !== want.pump ||
						seen.valve !== want.valve || seen.pressure !== want.pressure ||
						seen.ev !== want.ev || seen.loss !== want.loss) begin
						fails++;
						if (fails <= 10) begin
							$write("mismatch: expected mode %0d pump %0b valve %0b ",
								want.mode, want.pump, want.valve);
							$write("pressure %0d event %0d loss %0d, ",
								want.pressure, want.ev, want.loss);
							$write("got mode %0d pump %0b valve %0b ",
								seen.mode, seen.pump, seen.valve);
							$display("pressure %0d event %0d loss %0d",
								seen.pressure, seen.ev, seen.loss);
						end
					end
				end
			end

			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_TARGET:   target_p = longint'($signed(cfg.data[14:0]));
					REG_RAMP_TO:  ramp_lim = longint'(cfg.data[15:0]);
					REG_LEAK_LIM: leak_lim = longint'(cfg.data[12:0]);
					REG_LEAK_WIN: window_lim = longint'(cfg.data[16:0]);
					REG_SETTLE:   settle_lim = longint'(cfg.data[16:0]);
					REG_GAIN:     gain_q16 = longint'($signed(cfg.data[20:0]));
					REG_ZERO:     zero_p = longint'($signed(cfg.data[17:0]));
					REG_OFFSET:   offset_p = longint'($signed(cfg.data[13:0]));
					default: ;
				endcase
			end

			if (req.valid && req.ready)
				want_q.push_back(advance(req.func, req.adc_sample));

			fail_count <= fails;
			pending <= want_q.size();
		end
	end

endmodule

/* sim/tb_vacuum_leak_test_sequencer.sv */
// Testbench top of the vacuum leak test sequencer: drives items, register writes and
// result back-pressure, and prints the verdict. Depends on vlts_pkg, vlts_if, the
// block itself and the scoreboard in vlts_checker.
module tb_vacuum_leak_test_sequencer;
	import vlts_pkg::*;

	// Number of random items after the directed part, and the hard stop of the run.
	localparam int RANDOM_ITEMS = 1150;
	localparam int CYCLE_LIMIT  = 600000;

	logic   clk;
	logic   arst_n;
	int     cyc = 0;
	int     sent = 0;
	int     fail_count;
	int     pending;
	logic   calm;
	longint cfg_val [8];

	vlts_in_if  req_ch ();
	vlts_out_if rsp_ch ();
	vlts_cfg_if cfg_ch ();

	vacuum_leak_test_sequencer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// The scoreboard sits beside the block and sees every transaction on all three
	// channels; it hands back its failure count and the number of results still owed.
	vlts_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Cycle counter and watchdog. Reaching the limit means the block stopped
	// accepting items or returning results.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// One window in four is calm: neither side idles nor stalls there, so the block
	// also runs back to back at its full rate.
	assign calm = ((cyc / 1500) % 4) == 2;

	// Idle cycles the sender leaves before its next transaction: mostly none or a
	// few, now and then a long pause.
	function automatic int sender_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ADC count a few steps around a level, clamped to the converter range.
	function automatic logic [11:0] near(input int level);
		int v;
		v = level + int'($urandom_range(0, 8)) - 4;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return 12'(v);
	endfunction

	// Fast settings keep every time limit within a few dozen ticks so that the
	// random runs go all the way through pulldown, settling and measurement. The
	// sensor scale is about ten milli-psi per count from -20000 at count zero, so the
	// low counts reach the target and the higher ones do not. Now and then every
	// register gets a raw random word, values outside the usual ranges included.
	function automatic void pick_settings();
		if ($urandom_range(0, 7) == 0) begin
			for (int i = 0; i < 8; i++)
				cfg_val[i] = longint'($urandom);
		end else begin
			cfg_val[REG_TARGET] = -longint'($urandom_range(0, 15000));
			cfg_val[REG_RAMP_TO] = $urandom_range(0, 60);
			if ($urandom_range(0, 3) == 0)
				cfg_val[REG_LEAK_LIM] = $urandom_range(0, 20);
			else
				cfg_val[REG_LEAK_LIM] = $urandom_range(20, 3000);
			cfg_val[REG_LEAK_WIN] = $urandom_range(0, 40);
			cfg_val[REG_SETTLE] = $urandom_range(0, 20);
			cfg_val[REG_GAIN] = $urandom_range(500000, 800000);
			cfg_val[REG_ZERO] = -longint'($urandom_range(15000, 25000));
			cfg_val[REG_OFFSET] = longint'($urandom_range(0, 10000)) - 5000;
		end
	endfunction

	// One item transaction. The task starts and ends at a falling edge. The valid
	// is only lowered when a gap follows, so it is never dropped and raised again
	// within one time step.
	task automatic send_item(input func_t f, input logic [11:0] a);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.adc_sample <= a;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		sent++;
	endtask

	// Waits until every expected result has come back, then lets the block's
	// latency pass so that no item is still inside it.
	task automatic quiesce();
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Writes the registers selected by the mask from cfg_val, one transaction each.
	task automatic load_config(input logic [7:0] mask);
		for (int i = 0; i < 8; i++) begin
			if (mask[i]) begin
				cfg_ch.valid <= 1'b1;
				cfg_ch.index <= reg_idx_t'(i);
				cfg_ch.data <= CFG_W'(cfg_val[i]);
				do @(posedge clk); while (!cfg_ch.ready);
				@(negedge clk);
			end
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// A complete leak test: optionally a hold first, then the start command, a
	// stretch of low readings to pull the line down and a stretch at a second level
	// for the measurement. The second level equals the first most of the time, which
	// tends to pass, rises a little, which probes the leak limit, or rises a lot.
	// Sometimes the run is cut off by vacuum off.
	task automatic leak_run();
		int lo, hi, n_pull, n_meas, r;
		if ($urandom_range(0, 3) == 0)
			send_item(FUNC_ON, 12'($urandom));
		send_item(FUNC_LEAK, 12'($urandom));
		lo = $urandom_range(0, 1600);
		r = $urandom_range(0, 9);
		if (r < 5)
			hi = lo;
		else if (r < 8)
			hi = lo + int'($urandom_range(1, 30));
		else
			hi = lo + int'($urandom_range(30, 1500));
		n_pull = $urandom_range(3, 40);
		n_meas = $urandom_range(0, 50);
		repeat (n_pull) send_item(FUNC_TICK, near(lo));
		repeat (n_meas) send_item(FUNC_TICK, near(hi));
		if ($urandom_range(0, 2) == 0)
			send_item(FUNC_OFF, 12'($urandom));
	endtask

	// Vacuum hold with a few readings, sometimes turned into a leak test from hold.
	task automatic hold_run();
		int level;
		level = $urandom_range(0, 4095);
		send_item(FUNC_ON, 12'($urandom));
		repeat ($urandom_range(1, 8)) send_item(FUNC_TICK, near(level));
		if ($urandom_range(0, 1) == 0)
			send_item(FUNC_LEAK, 12'($urandom));
		send_item(FUNC_OFF, 12'($urandom));
	endtask

	// Items of any kind with any count, whatever mode the block is in.
	task automatic noise_burst();
		repeat ($urandom_range(1, 8))
			send_item(func_t'($urandom_range(0, 3)), 12'($urandom));
	endtask

	// The receiver takes results when it is ready. Most stalls are short, a few
	// are long, and there are none in the calm windows.
	initial begin : result_drain
		int hold;
		rsp_ch.ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 4) == 0)
						hold = $urandom_range(20, 60);
					else
						hold = $urandom_range(1, 3);
				end
			end
		end
	end

	initial begin : stimulus
		int first_random, r;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_TICK;
		req_ch.adc_sample = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TARGET;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Commands alone at the reset settings: vacuum off while already off, hold,
		// hold again from hold, a leak test started from hold, both commands rejected
		// while pulling down, and off out of pulldown.
		send_item(FUNC_OFF, 12'h000);
		send_item(FUNC_ON, 12'hFFF);
		send_item(FUNC_ON, 12'h000);
		send_item(FUNC_LEAK, 12'h000);
		send_item(FUNC_ON, 12'hFFF);
		send_item(FUNC_LEAK, 12'hFFF);
		send_item(FUNC_OFF, 12'h000);

		// Give the sensor a scale so that the first reading after reset, taken at
		// full scale without filtering, differs from the cleared filter. The
		// following low readings go through the filter, the last two during a pulldown.
		quiesce();
		cfg_val[REG_GAIN] = 655360;
		cfg_val[REG_ZERO] = -20000;
		load_config((8'd1 << REG_GAIN) | (8'd1 << REG_ZERO));
		send_item(FUNC_TICK, 12'hFFF);
		send_item(FUNC_TICK, 12'h000);
		send_item(FUNC_LEAK, 12'h000);
		send_item(FUNC_TICK, 12'h000);
		send_item(FUNC_TICK, 12'h000);
		send_item(FUNC_OFF, 12'h000);

		// Every register at its low end (zero and offset at their high end). The
		// unreachable target with no ramp time gives a pulldown timeout on the first
		// tick, with the valve left open; in error, a command is rejected and a tick
		// changes nothing until vacuum off.
		quiesce();
		cfg_val[REG_TARGET] = -16384;
		cfg_val[REG_RAMP_TO] = 0;
		cfg_val[REG_LEAK_LIM] = 0;
		cfg_val[REG_LEAK_WIN] = 0;
		cfg_val[REG_SETTLE] = 0;
		cfg_val[REG_GAIN] = -1048576;
		cfg_val[REG_ZERO] = 131071;
		cfg_val[REG_OFFSET] = 8191;
		load_config(8'hFF);
		send_item(FUNC_LEAK, 12'h000);
		send_item(FUNC_TICK, 12'hFFF);
		send_item(FUNC_ON, 12'h000);
		send_item(FUNC_TICK, 12'h000);
		send_item(FUNC_OFF, 12'hFFF);

		// The opposite ends. The target lies above any reading, so the line is
		// pulled down at once; with no settling time and no window, three ticks walk
		// through settling, measurement and the end of the window.
		quiesce();
		cfg_val[REG_TARGET] = 16383;
		cfg_val[REG_LEAK_LIM] = 8191;
		cfg_val[REG_GAIN] = 1048575;
		cfg_val[REG_ZERO] = -131072;
		cfg_val[REG_OFFSET] = -8192;
		load_config(8'hFF);
		send_item(FUNC_LEAK, 12'h800);
		send_item(FUNC_TICK, 12'h800);
		send_item(FUNC_TICK, 12'h800);
		send_item(FUNC_TICK, 12'h800);

		// The longest time limits the registers hold; the run is cut short by off.
		quiesce();
		cfg_val[REG_RAMP_TO] = 65535;
		cfg_val[REG_LEAK_WIN] = 131071;
		cfg_val[REG_SETTLE] = 131071;
		load_config((8'd1 << REG_RAMP_TO) | (8'd1 << REG_LEAK_WIN) | (8'd1 << REG_SETTLE));
		send_item(FUNC_LEAK, 12'h000);
		send_item(FUNC_TICK, 12'h7FF);
		send_item(FUNC_OFF, 12'h000);

		// Random phases: new settings while idle, then a handful of test sequences,
		// mostly complete leak tests with some holds and stray items mixed in.
		first_random = sent;
		while (sent < first_random + RANDOM_ITEMS) begin
			quiesce();
			pick_settings();
			load_config(($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'hFF);
			repeat ($urandom_range(2, 5)) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					leak_run();
				else if (r < 8)
					hold_run();
				else
					noise_burst();
			end
		end

		quiesce();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* vacuum_leak_test_sequencer.f */
+incdir+rtl
rtl/vlts_pkg.sv
rtl/vlts_if.sv
rtl/vlts_datapath.sv
rtl/vlts_ctrl.sv
rtl/vacuum_leak_test_sequencer.sv
sim/vlts_checker.sv
sim/tb_vacuum_leak_test_sequencer.sv
